/* rtl/pfc_pkg.sv */
`default_nettype none

package pfc_pkg;

  // Frame codes held in the in_kind and out_kind registers.
  localparam logic [1:0] KIND_STOKES   = 2'd0;
  localparam logic [1:0] KIND_CIRCULAR = 2'd1;
  localparam logic [1:0] KIND_LINEAR   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IN_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_KIND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_PRODUCTS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_PRODUCTS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_UNSPEC = 3'd6;

  // Number of product slots on either side.
  localparam int unsigned NUM_SLOTS = 4;

  // Conversion matrix selection.
  localparam int unsigned NUM_TBL = 5;
  localparam logic [2:0] TBL_LIN2STK  = 3'd0;
  localparam logic [2:0] TBL_CIRC2STK = 3'd1;
  localparam logic [2:0] TBL_STK2LIN  = 3'd2;
  localparam logic [2:0] TBL_STK2CIRC = 3'd3;
  localparam logic [2:0] TBL_IDENT    = 3'd4;

  // Coefficients times two, packed as {re[2:0], im[2:0]} in two's complement.
  localparam logic [5:0] C_Z   = 6'b000_000;
  localparam logic [5:0] C_P2  = 6'b010_000;
  localparam logic [5:0] C_N2  = 6'b110_000;
  localparam logic [5:0] C_J2  = 6'b000_010;
  localparam logic [5:0] C_NJ2 = 6'b000_110;
  localparam logic [5:0] C_P1  = 6'b001_000;
  localparam logic [5:0] C_N1  = 6'b111_000;
  localparam logic [5:0] C_J1  = 6'b000_001;
  localparam logic [5:0] C_NJ1 = 6'b000_111;

  // Indexed by table, then by {row, column} of the product indexes.
  localparam logic [5:0] COEF_TAB [NUM_TBL][16] = '{
    '{C_P2, C_Z,   C_Z,  C_P2,
      C_P2, C_Z,   C_Z,  C_N2,
      C_Z,  C_P2,  C_P2, C_Z,
      C_Z,  C_NJ2, C_J2, C_Z},
    '{C_P2, C_Z,   C_Z,  C_P2,
      C_Z,  C_NJ2, C_J2, C_Z,
      C_P2, C_Z,   C_Z,  C_N2,
      C_Z,  C_P2,  C_P2, C_Z},
    '{C_P1, C_P1,  C_Z,  C_Z,
      C_Z,  C_Z,   C_P1, C_J1,
      C_Z,  C_Z,   C_P1, C_NJ1,
      C_P1, C_N1,  C_Z,  C_Z},
    '{C_P1, C_Z,   C_P1, C_Z,
      C_Z,  C_J1,  C_Z,  C_P1,
      C_Z,  C_NJ1, C_Z,  C_P1,
      C_P1, C_Z,   C_N1, C_Z},
    '{C_P2, C_Z,   C_Z,  C_Z,
      C_Z,  C_P2,  C_Z,  C_Z,
      C_Z,  C_Z,   C_P2, C_Z,
      C_Z,  C_Z,   C_Z,  C_P2}
  };

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0] in_kind;
    logic [1:0] out_kind;
    logic [2:0] in_count;
    logic [2:0] out_count;
    logic [7:0] in_products;
    logic [7:0] out_products;
    logic       check_unspec;
  } pfc_cfg_t;

endpackage

`default_nettype wire

/* rtl/pfc_core.sv */
`default_nettype none

// Combinational conversion of one visibility: matrix selection, error checks,
// per-slot sums of scaled samples and saturation to the result width.
module pfc_core
  import pfc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  pfc_cfg_t                                cfg_i,
  input  logic [2*NUM_SLOTS*SAMPLE_BITS-1:0]      smp_i,
  output logic [2*NUM_SLOTS*(SAMPLE_BITS+2)-1:0]  res_o,
  output logic                                    err_o
);

  localparam int unsigned RES_W = SAMPLE_BITS + 2;
  localparam int unsigned ACC_W = SAMPLE_BITS + 4;

  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((1 << (RES_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] RES_MIN = -ACC_W'(1 << (RES_W - 1));

  // Multiply a sample by a coefficient in -2..2 with shifts and negation.
  function automatic logic signed [ACC_W-1:0] scale(input logic signed [ACC_W-1:0] s,
                                                     input logic [2:0] k);
    logic signed [ACC_W-1:0] v;
    case (k)
      3'b001:  v = s;
      3'b010:  v = s <<< 1;
      3'b111:  v = -s;
      3'b110:  v = -(s <<< 1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [RES_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > RES_MAX) begin
      c = RES_MAX;
    end else if (v < RES_MIN) begin
      c = RES_MIN;
    end else begin
      c = v;
    end
    return c[RES_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] sre [NUM_SLOTS];
  logic signed [ACC_W-1:0] sim [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    in_used;
  logic [NUM_SLOTS-1:0]    out_used;
  logic                    counts_ok;
  logic                    kinds_ok;
  logic                    same;
  logic                    tbl_ok;
  logic [2:0]              tbl;
  logic [3:0]              present;
  logic                    missing;
  logic                    err;

  // Sample extension and slot usage.
  always_comb begin
    for (int c = 0; c < NUM_SLOTS; c++) begin
      sre[c] = ACC_W'($signed(smp_i[(2*c)*SAMPLE_BITS +: SAMPLE_BITS]));
      sim[c] = ACC_W'($signed(smp_i[(2*c+1)*SAMPLE_BITS +: SAMPLE_BITS]));
      in_used[c]  = (3'(c) < cfg_i.in_count);
      out_used[c] = (3'(c) < cfg_i.out_count);
    end
  end

  // Frame checks and matrix selection.
  always_comb begin
    counts_ok = (cfg_i.in_count >= 3'd1) && (cfg_i.in_count <= 3'd4) &&
                (cfg_i.out_count >= 3'd1) && (cfg_i.out_count <= 3'd4);
    kinds_ok  = (cfg_i.in_kind != 2'd3) && (cfg_i.out_kind != 2'd3);

    same = (cfg_i.in_kind == cfg_i.out_kind) && (cfg_i.in_count == cfg_i.out_count);
    for (int c = 0; c < NUM_SLOTS; c++) begin
      if (in_used[c] &&
          (cfg_i.in_products[2*c +: 2] != cfg_i.out_products[2*c +: 2])) begin
        same = 1'b0;
      end
    end

    tbl    = TBL_IDENT;
    tbl_ok = 1'b1;
    if (cfg_i.out_kind == KIND_STOKES) begin
      if (cfg_i.in_kind == KIND_LINEAR) begin
        tbl = TBL_LIN2STK;
      end else if (cfg_i.in_kind == KIND_CIRCULAR) begin
        tbl = TBL_CIRC2STK;
      end
    end else if (cfg_i.in_kind == KIND_STOKES) begin
      tbl = (cfg_i.out_kind == KIND_LINEAR) ? TBL_STK2LIN : TBL_STK2CIRC;
    end else if (cfg_i.in_kind != cfg_i.out_kind) begin
      tbl_ok = 1'b0;
    end
    if (!kinds_ok) begin
      tbl_ok = 1'b0;
    end
  end

  // A used output row that needs a product no used input slot carries.
  always_comb begin
    present = '0;
    for (int c = 0; c < NUM_SLOTS; c++) begin
      if (in_used[c]) begin
        present[cfg_i.in_products[2*c +: 2]] = 1'b1;
      end
    end
    missing = 1'b0;
    for (int r = 0; r < NUM_SLOTS; r++) begin
      for (int p = 0; p < 4; p++) begin
        if (out_used[r] && !present[p] &&
            (COEF_TAB[tbl][{cfg_i.out_products[2*r +: 2], 2'(p)}] != C_Z)) begin
          missing = 1'b1;
        end
      end
    end
    err = !counts_ok || !kinds_ok ||
          (!same && (!tbl_ok || (cfg_i.check_unspec && missing)));
  end

  // Per result slot: sum over used input slots, or plain doubling on a pass-through.
  always_comb begin
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic [5:0]              k;
    res_o = '0;
    for (int r = 0; r < NUM_SLOTS; r++) begin
      acc_re = '0;
      acc_im = '0;
      for (int c = 0; c < NUM_SLOTS; c++) begin
        k = COEF_TAB[tbl][{cfg_i.out_products[2*r +: 2], cfg_i.in_products[2*c +: 2]}];
        if (in_used[c]) begin
          acc_re = acc_re + scale(sre[c], k[5:3]) - scale(sim[c], k[2:0]);
          acc_im = acc_im + scale(sim[c], k[5:3]) + scale(sre[c], k[2:0]);
        end
      end
      if (same) begin
        acc_re = sre[r] <<< 1;
        acc_im = sim[r] <<< 1;
      end
      if (!err && out_used[r]) begin
        res_o[(2*r)*RES_W +: RES_W]   = sat(acc_re);
        res_o[(2*r+1)*RES_W +: RES_W] = sat(acc_im);
      end
    end
  end

  assign err_o = err;

endmodule

`default_nettype wire

/* rtl/polarisation_frame_converter.sv */
`default_nettype none

// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | tdata: s0_re, s0_im, s1_re, ... s3_im (SAMPLE_BITS each)
// m_axis    | out       | tdata: r0_re, r0_im, ... r3_im (SAMPLE_BITS+2 each);
//           |           | tuser: config_error
// cfg       | in        | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One visibility is accepted per cycle while s_axis_tready is high; each result
// passes through the input register and then the result register, with the
// combinational matrix between them.
// Reset clears both valid flags and loads the configuration reset values.
// A stall on m_axis holds the result register; s_axis_tready falls only when
// both registers are full and the result is not being taken.
module polarisation_frame_converter
  import pfc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                  cfg_data_i,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // s0_re, s0_im, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im
  input  logic [2*NUM_SLOTS*SAMPLE_BITS-1:0]     s_axis_tdata,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // r0_re, r0_im, r1_re, r1_im, r2_re, r2_im, r3_re, r3_im
  output logic [2*NUM_SLOTS*(SAMPLE_BITS+2)-1:0] m_axis_tdata,
  // config_error
  output logic                                   m_axis_tuser
);

  localparam int unsigned IN_W  = 2 * NUM_SLOTS * SAMPLE_BITS;
  localparam int unsigned OUT_W = 2 * NUM_SLOTS * (SAMPLE_BITS + 2);

  pfc_cfg_t         cfg_q;
  logic             in_valid_q;
  logic [IN_W-1:0]  in_data_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic             out_err_q;
  logic [OUT_W-1:0] res;
  logic             res_err;
  logic             out_take;
  logic             in_take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_kind      <= KIND_STOKES;
      cfg_q.out_kind     <= KIND_STOKES;
      cfg_q.in_count     <= 3'd4;
      cfg_q.out_count    <= 3'd4;
      cfg_q.in_products  <= 8'd228;
      cfg_q.out_products <= 8'd228;
      cfg_q.check_unspec <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_KIND:      cfg_q.in_kind      <= cfg_data_i[1:0];
        REG_OUT_KIND:     cfg_q.out_kind     <= cfg_data_i[1:0];
        REG_IN_COUNT:     cfg_q.in_count     <= cfg_data_i[2:0];
        REG_OUT_COUNT:    cfg_q.out_count    <= cfg_data_i[2:0];
        REG_IN_PRODUCTS:  cfg_q.in_products  <= cfg_data_i;
        REG_OUT_PRODUCTS: cfg_q.out_products <= cfg_data_i;
        REG_CHECK_UNSPEC: cfg_q.check_unspec <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being taken.
  assign out_take      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_take;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_take) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
    end
    if (out_take && in_valid_q) begin
      out_data_q <= res;
      out_err_q  <= res_err;
    end
  end

  pfc_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .cfg_i(cfg_q),
    .smp_i(in_data_q),
    .res_o(res),
    .err_o(res_err)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

/* tb/polarisation_frame_converter_test.sv */
`timescale 1ns / 1ps

module polarisation_frame_converter_test;
  import pfc_pkg::*;

  localparam int unsigned SB = 16;
  localparam int unsigned RB = SB + 2;
  localparam int unsigned VIS_W = 2 * NUM_SLOTS * SB;
  localparam int unsigned RES_W = 2 * NUM_SLOTS * RB;
  localparam longint RES_MAX = (longint'(1) << (RB - 1)) - 1;
  localparam longint RES_MIN = -(longint'(1) << (RB - 1));
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned RANDOM_PHASES = 20;
  localparam int unsigned PHASE_ITEMS = 45;

  // Conversion matrices, coefficients times two, indexed by row * 4 + column.
  localparam int MAT_NONE     = -1;
  localparam int MAT_LIN2STK  = 0;
  localparam int MAT_CIRC2STK = 1;
  localparam int MAT_STK2LIN  = 2;
  localparam int MAT_STK2CIRC = 3;
  localparam int MAT_IDENT    = 4;
  localparam int MAT_RE [5][16] = '{
    '{2, 0, 0, 2,  2, 0, 0, -2,  0, 2, 2, 0,  0, 0, 0, 0},
    '{2, 0, 0, 2,  0, 0, 0, 0,  2, 0, 0, -2,  0, 2, 2, 0},
    '{1, 1, 0, 0,  0, 0, 1, 0,  0, 0, 1, 0,  1, -1, 0, 0},
    '{1, 0, 1, 0,  0, 0, 0, 1,  0, 0, 0, 1,  1, 0, -1, 0},
    '{2, 0, 0, 0,  0, 2, 0, 0,  0, 0, 2, 0,  0, 0, 0, 2}
  };
  localparam int MAT_IM [5][16] = '{
    '{0, 0, 0, 0,  0, 0, 0, 0,  0, 0, 0, 0,  0, -2, 2, 0},
    '{0, 0, 0, 0,  0, -2, 2, 0,  0, 0, 0, 0,  0, 0, 0, 0},
    '{0, 0, 0, 0,  0, 0, 0, 1,  0, 0, 0, -1,  0, 0, 0, 0},
    '{0, 0, 0, 0,  0, 1, 0, 0,  0, -1, 0, 0,  0, 0, 0, 0},
    '{0, 0, 0, 0,  0, 0, 0, 0,  0, 0, 0, 0,  0, 0, 0, 0}
  };

  // Stall patterns, one per phase.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  typedef struct {
    logic [RES_W-1:0] data;
    logic             config_error;
  } stokes_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // s0_re, s0_im, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im
  logic [VIS_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // r0_re, r0_im, r1_re, r1_im, r2_re, r2_im, r3_re, r3_im
  logic [RES_W-1:0] m_axis_tdata;
  // config_error
  logic m_axis_tuser;

  pfc_cfg_t frame_cfg = '{in_kind: KIND_STOKES, out_kind: KIND_STOKES, in_count: 3'd4,
                          out_count: 3'd4, in_products: 8'd228, out_products: 8'd228,
                          check_unspec: 1'b1};
  logic [VIS_W-1:0] pending_visibilities [$];
  stokes_result_t expected_results [$];
  int fail_count = 0;
  int idle_mode = IDLE_NONE;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int unsigned cycle_count = 0;

  polarisation_frame_converter #(
    .SAMPLE_BITS(SB)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [RB-1:0] saturate(input longint v);
    if (v > RES_MAX) v = RES_MAX;
    if (v < RES_MIN) v = RES_MIN;
    return v[RB-1:0];
  endfunction

  function automatic int slot_product(input logic [7:0] products, input int slot);
    return int'(products[2*slot +: 2]);
  endfunction

  function automatic int select_matrix(input logic [1:0] ik, input logic [1:0] ok);
    if (ok == KIND_STOKES) begin
      if (ik == KIND_LINEAR) return MAT_LIN2STK;
      if (ik == KIND_CIRCULAR) return MAT_CIRC2STK;
      return MAT_IDENT;
    end
    if (ik == KIND_STOKES) return (ok == KIND_LINEAR) ? MAT_STK2LIN : MAT_STK2CIRC;
    if (ik == ok) return MAT_IDENT;
    return MAT_NONE;
  endfunction

  // Expected output of one visibility under the given frame setting.
  function automatic stokes_result_t convert_visibility(input pfc_cfg_t c,
                                                        input logic [VIS_W-1:0] vis);
    stokes_result_t res;
    longint s_re [4];
    longint s_im [4];
    longint acc_re, acc_im, a, b;
    int nin, nout, m, k, r, p, ri, ci;
    bit same;
    bit present [4];
    res.data = '0;
    res.config_error = 1'b0;
    nin = int'(c.in_count);
    nout = int'(c.out_count);
    if (nin < 1 || nin > 4 || nout < 1 || nout > 4 ||
        c.in_kind > KIND_LINEAR || c.out_kind > KIND_LINEAR) begin
      res.config_error = 1'b1;
      return res;
    end
    for (k = 0; k < 4; k++) begin
      s_re[k] = longint'($signed(vis[2*SB*k +: SB]));
      s_im[k] = longint'($signed(vis[2*SB*k+SB +: SB]));
    end

    // Matching frames pass the samples through.
    same = (c.in_kind == c.out_kind) && (nin == nout);
    for (k = 0; k < nin; k++)
      if (slot_product(c.in_products, k) != slot_product(c.out_products, k)) same = 1'b0;
    if (same) begin
      for (k = 0; k < nin; k++) begin
        res.data[2*RB*k +: RB] = saturate(2 * s_re[k]);
        res.data[2*RB*k+RB +: RB] = saturate(2 * s_im[k]);
      end
      return res;
    end

    m = select_matrix(c.in_kind, c.out_kind);
    if (m == MAT_NONE) begin
      res.config_error = 1'b1;
      return res;
    end

    // A used output row may not depend on a product that no input slot carries.
    if (c.check_unspec) begin
      for (p = 0; p < 4; p++) present[p] = 1'b0;
      for (k = 0; k < nin; k++) present[slot_product(c.in_products, k)] = 1'b1;
      for (r = 0; r < nout; r++) begin
        ri = slot_product(c.out_products, r);
        for (p = 0; p < 4; p++)
          if (!present[p] && (MAT_RE[m][4*ri+p] != 0 || MAT_IM[m][4*ri+p] != 0)) begin
            res.config_error = 1'b1;
            res.data = '0;
            return res;
          end
      end
    end

    for (r = 0; r < nout; r++) begin
      ri = slot_product(c.out_products, r);
      acc_re = 0;
      acc_im = 0;
      for (k = 0; k < nin; k++) begin
        ci = slot_product(c.in_products, k);
        a = MAT_RE[m][4*ri+ci];
        b = MAT_IM[m][4*ri+ci];
        acc_re += a * s_re[k] - b * s_im[k];
        acc_im += a * s_im[k] + b * s_re[k];
      end
      res.data[2*RB*r +: RB] = saturate(acc_re);
      res.data[2*RB*r+RB +: RB] = saturate(acc_im);
    end
    return res;
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 75;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 33;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(99) < 75;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 33;
    return 1'b0;
  endfunction

  // Sender: predicts each accepted visibility and offers the next pending one.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(),
                                convert_visibility(frame_cfg, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (pending_visibilities.size() > 0) && !sender_idles();
        if (offer) s_axis_tdata <= pending_visibilities.pop_front();
        s_axis_tvalid <= offer;
      end
    end
  end

  // Receiver: checks every result transfer and drives the stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    stokes_result_t want;
    int k;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          for (k = 0; k < 2 * NUM_SLOTS; k++)
            if (m_axis_tdata[RB*k +: RB] !== want.data[RB*k +: RB]) begin
              $error("r%0d_%s: expected %0d, got %0d", k / 2, (k % 2) ? "im" : "re",
                     $signed(want.data[RB*k +: RB]), $signed(m_axis_tdata[RB*k +: RB]));
              fail_count++;
            end
          if (m_axis_tuser !== want.config_error) begin
            $error("config_error: expected %0d, got %0d", want.config_error, m_axis_tuser);
            fail_count++;
          end
        end
      end
      // A long hold-off lets the pipeline fill and push back on the input.
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !receiver_stalls();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_IN_KIND:      frame_cfg.in_kind = val[1:0];
      REG_OUT_KIND:     frame_cfg.out_kind = val[1:0];
      REG_IN_COUNT:     frame_cfg.in_count = val[2:0];
      REG_OUT_COUNT:    frame_cfg.out_count = val[2:0];
      REG_IN_PRODUCTS:  frame_cfg.in_products = val;
      REG_OUT_PRODUCTS: frame_cfg.out_products = val;
      REG_CHECK_UNSPEC: frame_cfg.check_unspec = val[0];
      default: ;
    endcase
  endtask

  task automatic set_frames(input logic [1:0] ik, input logic [1:0] ok,
                            input logic [2:0] ic, input logic [2:0] oc,
                            input logic [7:0] ip, input logic [7:0] op, input bit chk);
    write_reg(REG_IN_KIND, 8'(ik));
    write_reg(REG_OUT_KIND, 8'(ok));
    write_reg(REG_IN_COUNT, 8'(ic));
    write_reg(REG_OUT_COUNT, 8'(oc));
    write_reg(REG_IN_PRODUCTS, ip);
    write_reg(REG_OUT_PRODUCTS, op);
    write_reg(REG_CHECK_UNSPEC, 8'(chk));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every pending visibility is sent and every result has come back.
  task automatic wait_drained();
    while (pending_visibilities.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Appends one visibility to the end of the pending queue.
  task automatic queue_visibility(input logic [VIS_W-1:0] vis);
    pending_visibilities.insert(pending_visibilities.size(), vis);
  endtask

  function automatic logic [VIS_W-1:0] random_visibility();
    logic [VIS_W-1:0] vis;
    int k;
    for (k = 0; k < 2 * NUM_SLOTS; k++)
      case ($urandom_range(7))
        0: vis[SB*k +: SB] = 16'h7fff;
        1: vis[SB*k +: SB] = 16'h8000;
        default: vis[SB*k +: SB] = 16'($urandom);
      endcase
    return vis;
  endfunction

  // Queues one visibility with the given word in every sample and one random one.
  task automatic send_pair(input logic [15:0] word);
    queue_visibility({8{word}});
    queue_visibility(random_visibility());
  endtask

  function automatic logic [1:0] random_kind();
    return ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
  endfunction

  function automatic logic [2:0] random_count();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
  endfunction

  function automatic logic [7:0] random_products();
    return ($urandom_range(3) == 0) ? 8'd228 : 8'($urandom_range(255));
  endfunction

  initial begin : stimulus
    int phase, n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: Stokes to Stokes, samples pass through.
    queue_visibility('0);
    queue_visibility({8{16'h7fff}});
    queue_visibility({8{16'h8000}});
    queue_visibility({4{16'h5555, 16'haaaa}});
    wait_drained();

    // One setting per non-identity conversion matrix.
    set_frames(KIND_LINEAR, KIND_STOKES, 3'd4, 3'd4, 8'd228, 8'd228, 1'b1);
    send_pair(16'h7fff);
    wait_drained();
    set_frames(KIND_CIRCULAR, KIND_STOKES, 3'd4, 3'd4, 8'd228, 8'd228, 1'b1);
    send_pair(16'h8000);
    wait_drained();
    set_frames(KIND_STOKES, KIND_LINEAR, 3'd4, 3'd4, 8'd228, 8'd228, 1'b1);
    send_pair(16'h7fff);
    wait_drained();
    set_frames(KIND_STOKES, KIND_CIRCULAR, 3'd4, 3'd4, 8'd228, 8'd228, 1'b1);
    send_pair(16'h8000);
    wait_drained();

    // Linear to circular is unsupported.
    set_frames(KIND_LINEAR, KIND_CIRCULAR, 3'd4, 3'd4, 8'd228, 8'd228, 1'b0);
    send_pair(16'h1234);
    wait_drained();
    // Frame code three, and counts out of range.
    set_frames(2'd3, KIND_STOKES, 3'd0, 3'd7, 8'd0, 8'd255, 1'b0);
    send_pair(16'hffff);
    wait_drained();
    // Only Stokes I present while linear outputs also need Q.
    set_frames(KIND_STOKES, KIND_LINEAR, 3'd1, 3'd4, 8'd0, 8'd228, 1'b1);
    send_pair(16'h7fff);
    wait_drained();
    // Repeated XX in every slot feeds outputs that take no XX term; unused output slots read zero.
    set_frames(KIND_LINEAR, KIND_STOKES, 3'd4, 3'd2, 8'd0, 8'd255, 1'b0);
    send_pair(16'h7fff);
    queue_visibility({8{16'h8000}});
    wait_drained();
    // Same frame with reordered products goes through the identity matrix.
    set_frames(KIND_CIRCULAR, KIND_CIRCULAR, 3'd3, 3'd3, 8'h1b, 8'he4, 1'b1);
    send_pair(16'h7fff);
    wait_drained();

    // Random settings and visibilities, cycling through the stall patterns.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        set_frames(KIND_CIRCULAR, KIND_STOKES, 3'd4, 3'd4, 8'd228, 8'd228, 1'b1);
      else
        set_frames(random_kind(), random_kind(), random_count(), random_count(),
                   random_products(), random_products(), 1'($urandom_range(1)));
      idle_mode = phase % 4;
      @(negedge clk_i);
      if (phase == 0) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++)
        queue_visibility(random_visibility());
      wait_drained();
    end

    idle_mode = IDLE_NONE;
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
